@@ sv/snd_pkg.sv @@
// ----------------------------------------------------------------------------
// Slotted neighbour discovery package
// Shared widths, codes, reset values and the structs that pass between the
// top level and the sequencer core.
// ----------------------------------------------------------------------------
package snd_pkg;

	localparam int ID_SPACE_DEF   = 256;
	localparam int TICK_WIDTH_DEF = 24;

	localparam int CFG_TICK_W  = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int KIND_W      = 2;
	localparam int RX_LEN_W    = 7;
	localparam int RX_BYTE_W   = 8;
	localparam int SLOT_W      = 8;
	localparam int EPOCH_W     = 16;
	localparam int COUNT_W     = 9;

	localparam logic [CFG_TICK_W-1:0] SLOT_TICKS_RST   = 24'd1000;
	localparam logic [CFG_TICK_W-1:0] BEACON_TICKS_RST = 24'd33;
	localparam logic [CFG_TICK_W-1:0] RX_TICKS_RST     = 24'd99;
	localparam logic [SLOT_W-1:0]     EPOCH_SLOTS_RST  = 8'd10;
	localparam logic [RX_BYTE_W-1:0]  OWN_ID_RST       = 8'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_RX    = 2'd1,
		KIND_START = 2'd2
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BURST_MODE   = 3'd0,
		REG_SLOT_TICKS   = 3'd1,
		REG_BEACON_TICKS = 3'd2,
		REG_RX_TICKS     = 3'd3,
		REG_EPOCH_SLOTS  = 3'd4,
		REG_OWN_ID       = 3'd5
	} reg_index_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_TX     = 4'b0010,
		PH_LISTEN = 4'b0100,
		PH_QUIET  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic                  burst_mode;
		logic [CFG_TICK_W-1:0] slot_ticks;
		logic [CFG_TICK_W-1:0] beacon_ticks;
		logic [CFG_TICK_W-1:0] rx_ticks;
		logic [SLOT_W-1:0]     epoch_slots;
		logic [RX_BYTE_W-1:0]  own_id;
	} cfg_t;

	typedef struct packed {
		kind_t                kind;
		logic [RX_LEN_W-1:0]  rx_length;
		logic [RX_BYTE_W-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic                 beacon;
		logic                 radio_on;
		logic                 transmitting;
		logic                 new_neighbour;
		logic [RX_BYTE_W-1:0] neighbour_id;
		logic [EPOCH_W-1:0]   neighbour_epoch;
		logic                 epoch_done;
		logic [EPOCH_W-1:0]   done_epoch;
		logic [COUNT_W-1:0]   done_count;
	} result_t;

endpackage

@@ sv/snd_core.sv @@
// ----------------------------------------------------------------------------
// Slotted neighbour discovery sequencer core
// Holds the slot and epoch state and the seen-ID map, and works out the next
// state and the result of one item combinationally.
// ----------------------------------------------------------------------------
module snd_core #(
	parameter int ID_SPACE   = snd_pkg::ID_SPACE_DEF,
	parameter int TICK_WIDTH = snd_pkg::TICK_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  snd_pkg::item_t  item,
	input  snd_pkg::cfg_t   cfg,
	output snd_pkg::result_t res
);

	localparam int IDW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
	localparam int IDCW = snd_pkg::RX_BYTE_W + 1;

	snd_pkg::phase_t                phase_q, n_phase;
	logic [TICK_WIDTH-1:0]          srem_q, n_srem;
	logic [TICK_WIDTH-1:0]          timer_q, n_timer;
	logic [snd_pkg::SLOT_W-1:0]     slots_q, n_slots, slots_dec;
	logic [snd_pkg::EPOCH_W-1:0]    epoch_q, n_epoch;
	logic [snd_pkg::COUNT_W-1:0]    ncnt_q, n_ncnt;
	logic                           intx_q, n_intx;
	logic [ID_SPACE-1:0]            seen_q;

	logic [TICK_WIDTH-1:0] st, bt, rt, srem_b, tx_tmr_start, tx_tmr_b, quiet_tmr, rx_tmr;
	logic                  burst;
	logic                  begin_tx, begin_rx, finish, rx_over, clear_map, set_map;
	logic [IDW-1:0]        id_idx;
	logic                  id_ok;

	assign burst        = cfg.burst_mode;
	assign st           = TICK_WIDTH'(cfg.slot_ticks);
	assign bt           = TICK_WIDTH'(cfg.beacon_ticks);
	assign rt           = TICK_WIDTH'(cfg.rx_ticks);
	assign srem_b       = srem_q - bt;
	assign tx_tmr_start = (burst && st >= bt) ? bt : st;
	assign tx_tmr_b     = (burst && srem_b >= bt) ? bt : srem_b;
	assign quiet_tmr    = (st > rt) ? (st - rt) : '0;
	assign rx_tmr       = burst ? rt : st;
	assign slots_dec    = (slots_q != '0) ? (slots_q - snd_pkg::SLOT_W'(1)) : '0;
	assign id_idx       = IDW'(item.rx_byte);
	assign id_ok        = (IDCW'(item.rx_byte) < IDCW'(ID_SPACE));

	always_comb begin
		n_phase   = phase_q;
		n_srem    = srem_q;
		n_timer   = timer_q;
		n_slots   = slots_q;
		n_epoch   = epoch_q;
		n_ncnt    = ncnt_q;
		n_intx    = intx_q;
		begin_tx  = 1'b0;
		begin_rx  = 1'b0;
		finish    = 1'b0;
		rx_over   = 1'b0;
		clear_map = 1'b0;
		set_map   = 1'b0;
		res       = '0;

		unique case (item.kind)
			snd_pkg::KIND_TICK: begin
				if (phase_q != snd_pkg::PH_IDLE) begin
					if (timer_q > TICK_WIDTH'(1)) begin
						n_timer = timer_q - TICK_WIDTH'(1);
					end else begin
						unique case (phase_q)
							snd_pkg::PH_TX: begin
								if (burst && srem_q >= bt) begin
									n_srem     = srem_b;
									res.beacon = 1'b1;
									n_timer    = tx_tmr_b;
								end else begin
									n_slots = slots_dec;
									n_intx  = 1'b0;
									if (burst) begin
										begin_rx = 1'b1;
									end else if (slots_dec != '0) begin
										begin_tx = 1'b1;
									end else begin
										finish   = 1'b1;
										begin_rx = 1'b1;
									end
								end
							end
							snd_pkg::PH_LISTEN: begin
								if (burst) begin
									n_phase = snd_pkg::PH_QUIET;
									n_timer = quiet_tmr;
								end else begin
									rx_over = 1'b1;
								end
							end
							snd_pkg::PH_QUIET: begin
								rx_over = 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
			end
			snd_pkg::KIND_RX: begin
				if (!intx_q && item.rx_length == snd_pkg::RX_LEN_W'(1)
						&& item.rx_byte != '0 && id_ok && !seen_q[id_idx]) begin
					set_map             = 1'b1;
					n_ncnt              = ncnt_q + snd_pkg::COUNT_W'(1);
					res.new_neighbour   = 1'b1;
					res.neighbour_id    = item.rx_byte;
					res.neighbour_epoch = epoch_q;
				end
			end
			snd_pkg::KIND_START: begin
				n_epoch  = snd_pkg::EPOCH_W'(1);
				n_slots  = cfg.epoch_slots;
				n_ncnt   = '0;
				begin_tx = 1'b1;
			end
			default: begin
			end
		endcase

		if (rx_over) begin
			n_slots = slots_dec;
			if (!burst) begin
				begin_tx = 1'b1;
			end else if (slots_dec != '0) begin
				begin_rx = 1'b1;
			end else begin
				finish   = 1'b1;
				begin_tx = 1'b1;
			end
		end

		if (finish) begin
			res.epoch_done = 1'b1;
			res.done_epoch = epoch_q;
			res.done_count = ncnt_q;
			n_slots        = cfg.epoch_slots;
			n_epoch        = epoch_q + snd_pkg::EPOCH_W'(1);
			n_ncnt         = '0;
			clear_map      = 1'b1;
		end

		if (begin_rx) begin
			n_phase = snd_pkg::PH_LISTEN;
			n_timer = rx_tmr;
		end

		if (begin_tx) begin
			n_phase    = snd_pkg::PH_TX;
			n_intx     = 1'b1;
			n_srem     = st;
			res.beacon = 1'b1;
			n_timer    = tx_tmr_start;
		end

		res.radio_on     = (n_phase == snd_pkg::PH_LISTEN);
		res.transmitting = n_intx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= snd_pkg::PH_IDLE;
			srem_q  <= '0;
			timer_q <= '0;
			slots_q <= '0;
			epoch_q <= snd_pkg::EPOCH_W'(1);
			ncnt_q  <= '0;
			intx_q  <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			srem_q  <= n_srem;
			timer_q <= n_timer;
			slots_q <= n_slots;
			epoch_q <= n_epoch;
			ncnt_q  <= n_ncnt;
			intx_q  <= n_intx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (step) begin
			if (clear_map) begin
				seen_q <= '0;
			end else if (set_map) begin
				seen_q[id_idx] <= 1'b1;
			end
		end
	end

endmodule

@@ sv/slotted_neighbour_discovery.sv @@
// An accepted input item is held in the input register, and its result is
// registered in the output register when the output side can take it.
// Throughput: one item per cycle while the output is not stalled by m_tready;
// an input register, the sequencer core update and the output register set that rate.
// Reset clears all control state and the seen-ID map at once and loads the
// register defaults; the block is ready for items as soon as reset is released.
// ----------------------------------------------------------------------------
// Slotted neighbour discovery top level
// Stream input and output stages, configuration registers and the sequencer
// core that runs the slot, beacon and epoch logic.
// ----------------------------------------------------------------------------
module slotted_neighbour_discovery #(
	parameter int ID_SPACE   = snd_pkg::ID_SPACE_DEF,
	parameter int TICK_WIDTH = snd_pkg::TICK_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,   // rx_length, rx_byte, zero pad
	input  logic [snd_pkg::KIND_W-1:0]       s_tuser,   // kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [55:0]                      m_tdata,   // beacon, radio_on, transmitting,
	                                                    // neighbour_id, neighbour_epoch,
	                                                    // done_epoch, done_count, zero pad
	output logic [1:0]                       m_tuser,   // new_neighbour, epoch_done
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [snd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [snd_pkg::CFG_TICK_W-1:0]   cfg_data
);

	snd_pkg::cfg_t    cfg_q;
	snd_pkg::item_t   item_s1;
	logic             valid_s1;
	snd_pkg::result_t res, res_q;
	logic             out_v_q;
	logic             advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_v_q || m_tready);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_mode   <= 1'b0;
			cfg_q.slot_ticks   <= snd_pkg::SLOT_TICKS_RST;
			cfg_q.beacon_ticks <= snd_pkg::BEACON_TICKS_RST;
			cfg_q.rx_ticks     <= snd_pkg::RX_TICKS_RST;
			cfg_q.epoch_slots  <= snd_pkg::EPOCH_SLOTS_RST;
			cfg_q.own_id       <= snd_pkg::OWN_ID_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				snd_pkg::REG_BURST_MODE:   cfg_q.burst_mode   <= cfg_data[0];
				snd_pkg::REG_SLOT_TICKS:   cfg_q.slot_ticks   <= cfg_data;
				snd_pkg::REG_BEACON_TICKS: cfg_q.beacon_ticks <= cfg_data;
				snd_pkg::REG_RX_TICKS:     cfg_q.rx_ticks     <= cfg_data;
				snd_pkg::REG_EPOCH_SLOTS:  cfg_q.epoch_slots  <= cfg_data[snd_pkg::SLOT_W-1:0];
				snd_pkg::REG_OWN_ID:       cfg_q.own_id       <= cfg_data[snd_pkg::RX_BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind      <= snd_pkg::kind_t'(s_tuser);
			item_s1.rx_length <= s_tdata[6:0];
			item_s1.rx_byte   <= s_tdata[14:7];
		end
	end

	snd_core #(
		.ID_SPACE   (ID_SPACE),
		.TICK_WIDTH (TICK_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = {res_q.epoch_done, res_q.new_neighbour};
	assign m_tdata  = {4'b0, res_q.done_count, res_q.done_epoch, res_q.neighbour_epoch,
		res_q.neighbour_id, res_q.transmitting, res_q.radio_on, res_q.beacon};

endmodule

@@ sim/slotted_neighbour_discovery_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slotted neighbour discovery testbench
// Drives ticks, received packets and start commands through the input stream
// and checks every report on the output stream against a cycle-free model of
// the slot, beacon and epoch sequencing. Runs short directed parts and then
// random phases under several register settings, with random idling on both
// streams.
// ----------------------------------------------------------------------------
module slotted_neighbour_discovery_tb;

	localparam logic [snd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [snd_pkg::CFG_TICK_W-1:0] TICK_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [snd_pkg::KIND_W-1:0]    kind;
		logic [snd_pkg::RX_LEN_W-1:0]  len;
		logic [snd_pkg::RX_BYTE_W-1:0] id;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata;
	logic [snd_pkg::KIND_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [snd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [snd_pkg::CFG_TICK_W-1:0] cfg_data = '0;

	stim_t s_item = '0;
	stim_t pending_items[$];
	snd_pkg::result_t expected_reports[$];
	bit item_taken = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int idle_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;

	// Model state and register copies.
	logic                           set_burst;
	logic [snd_pkg::CFG_TICK_W-1:0] set_slot_ticks, set_beacon_ticks, set_rx_ticks;
	logic [snd_pkg::SLOT_W-1:0]     set_epoch_slots;
	logic [snd_pkg::RX_BYTE_W-1:0]  set_own_id;
	snd_pkg::phase_t                cur_phase;
	logic [snd_pkg::CFG_TICK_W-1:0] slot_left, phase_left;
	logic [snd_pkg::SLOT_W-1:0]     slots_to_go;
	logic [snd_pkg::EPOCH_W-1:0]    epoch_no;
	logic [snd_pkg::COUNT_W-1:0]    found_count;
	logic                           in_tx_slot;
	logic                           seen_map [256];
	snd_pkg::result_t               step_report;

	assign s_tdata = {1'b0, s_item.id, s_item.len};
	assign s_tuser = s_item.kind;

	slotted_neighbour_discovery dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void arm_beacon_timer();
		if (set_burst && slot_left >= set_beacon_ticks) begin
			phase_left = set_beacon_ticks;
		end else begin
			phase_left = slot_left;
		end
	endfunction

	function automatic void open_tx_slot();
		cur_phase = snd_pkg::PH_TX;
		in_tx_slot = 1'b1;
		slot_left = set_slot_ticks;
		step_report.beacon = 1'b1;
		arm_beacon_timer();
	endfunction

	function automatic void open_rx_slot();
		cur_phase = snd_pkg::PH_LISTEN;
		phase_left = set_burst ? set_rx_ticks : set_slot_ticks;
	endfunction

	function automatic void close_epoch();
		step_report.epoch_done = 1'b1;
		step_report.done_epoch = epoch_no;
		step_report.done_count = found_count;
		slots_to_go = set_epoch_slots;
		epoch_no = epoch_no + 1'b1;
		found_count = '0;
		foreach (seen_map[i]) seen_map[i] = 1'b0;
	endfunction

	function automatic void close_listen_slot();
		if (slots_to_go != 0) slots_to_go = slots_to_go - 1'b1;
		if (!set_burst) begin
			open_tx_slot();
		end else if (slots_to_go != 0) begin
			open_rx_slot();
		end else begin
			close_epoch();
			open_tx_slot();
		end
	endfunction

	function automatic snd_pkg::result_t discovery_step(input stim_t it);
		step_report = '0;
		case (it.kind)
			snd_pkg::KIND_TICK: begin
				if (cur_phase != snd_pkg::PH_IDLE) begin
					if (phase_left > 1) begin
						phase_left = phase_left - 1'b1;
					end else begin
						case (cur_phase)
							snd_pkg::PH_TX: begin
								if (set_burst && slot_left >= set_beacon_ticks) begin
									slot_left = slot_left - set_beacon_ticks;
									step_report.beacon = 1'b1;
									arm_beacon_timer();
								end else begin
									if (slots_to_go != 0) slots_to_go = slots_to_go - 1'b1;
									in_tx_slot = 1'b0;
									if (set_burst) begin
										open_rx_slot();
									end else if (slots_to_go != 0) begin
										open_tx_slot();
									end else begin
										close_epoch();
										open_rx_slot();
									end
								end
							end
							snd_pkg::PH_LISTEN: begin
								if (set_burst) begin
									cur_phase = snd_pkg::PH_QUIET;
									phase_left = (set_slot_ticks > set_rx_ticks) ?
										set_slot_ticks - set_rx_ticks : '0;
								end else begin
									close_listen_slot();
								end
							end
							snd_pkg::PH_QUIET: close_listen_slot();
							default: ;
						endcase
					end
				end
			end
			snd_pkg::KIND_RX: begin
				if (!in_tx_slot && it.len == 1 && it.id != 0
						&& int'(it.id) < snd_pkg::ID_SPACE_DEF && !seen_map[it.id]) begin
					seen_map[it.id] = 1'b1;
					found_count = found_count + 1'b1;
					step_report.new_neighbour = 1'b1;
					step_report.neighbour_id = it.id;
					step_report.neighbour_epoch = epoch_no;
				end
			end
			snd_pkg::KIND_START: begin
				epoch_no = snd_pkg::EPOCH_W'(1);
				slots_to_go = set_epoch_slots;
				found_count = '0;
				open_tx_slot();
			end
			default: ;
		endcase
		step_report.radio_on = (cur_phase == snd_pkg::PH_LISTEN);
		step_report.transmitting = in_tx_slot;
		return step_report;
	endfunction

	function automatic stim_t make_item(input logic [snd_pkg::KIND_W-1:0] kind,
			input logic [snd_pkg::RX_LEN_W-1:0] len,
			input logic [snd_pkg::RX_BYTE_W-1:0] id);
		stim_t it;
		it.kind = kind;
		it.len = len;
		it.id = id;
		return it;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic write_reg(input snd_pkg::reg_index_t idx,
			input logic [snd_pkg::CFG_TICK_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			snd_pkg::REG_BURST_MODE:   set_burst = val[0];
			snd_pkg::REG_SLOT_TICKS:   set_slot_ticks = val;
			snd_pkg::REG_BEACON_TICKS: set_beacon_ticks = val;
			snd_pkg::REG_RX_TICKS:     set_rx_ticks = val;
			snd_pkg::REG_EPOCH_SLOTS:  set_epoch_slots = val[snd_pkg::SLOT_W-1:0];
			snd_pkg::REG_OWN_ID:       set_own_id = val[snd_pkg::RX_BYTE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic burst, input logic [snd_pkg::CFG_TICK_W-1:0] slot,
			input logic [snd_pkg::CFG_TICK_W-1:0] beacon,
			input logic [snd_pkg::CFG_TICK_W-1:0] rx,
			input logic [snd_pkg::SLOT_W-1:0] total,
			input logic [snd_pkg::RX_BYTE_W-1:0] own);
		write_reg(snd_pkg::REG_BURST_MODE, {23'd0, burst});
		write_reg(snd_pkg::REG_SLOT_TICKS, slot);
		write_reg(snd_pkg::REG_BEACON_TICKS, beacon);
		write_reg(snd_pkg::REG_RX_TICKS, rx);
		write_reg(snd_pkg::REG_EPOCH_SLOTS, {16'd0, total});
		write_reg(snd_pkg::REG_OWN_ID, {16'd0, own});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (pending_items.size() != 0 || s_tvalid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_reports.push_back(discovery_step(s_item));
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (item_taken || !s_tvalid) begin
			item_taken = 1'b0;
			if (send_gap != 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
				send_gap = $urandom_range(0, 4);
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				s_item <= pending_items.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (recv_gap != 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			recv_gap = $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : report_check
		snd_pkg::result_t got, want;
		if (m_tvalid && m_tready) begin
			got.beacon = m_tdata[0];
			got.radio_on = m_tdata[1];
			got.transmitting = m_tdata[2];
			got.neighbour_id = m_tdata[10:3];
			got.neighbour_epoch = m_tdata[26:11];
			got.done_epoch = m_tdata[42:27];
			got.done_count = m_tdata[51:43];
			got.new_neighbour = m_tuser[0];
			got.epoch_done = m_tuser[1];
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected transaction, expected none actual %h %h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				check_field("beacon", want.beacon, got.beacon);
				check_field("radio_on", want.radio_on, got.radio_on);
				check_field("transmitting", want.transmitting, got.transmitting);
				check_field("new_neighbour", want.new_neighbour, got.new_neighbour);
				check_field("neighbour_id", want.neighbour_id, got.neighbour_id);
				check_field("neighbour_epoch", want.neighbour_epoch, got.neighbour_epoch);
				check_field("epoch_done", want.epoch_done, got.epoch_done);
				check_field("done_epoch", want.done_epoch, got.done_epoch);
				check_field("done_count", want.done_count, got.done_count);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL slotted_neighbour_discovery");
		$finish;
	end

	initial begin : run
		int r;
		logic [snd_pkg::RX_BYTE_W-1:0] pick_id;
		set_burst = 1'b0;
		set_slot_ticks = snd_pkg::SLOT_TICKS_RST;
		set_beacon_ticks = snd_pkg::BEACON_TICKS_RST;
		set_rx_ticks = snd_pkg::RX_TICKS_RST;
		set_epoch_slots = snd_pkg::EPOCH_SLOTS_RST;
		set_own_id = snd_pkg::OWN_ID_RST;
		cur_phase = snd_pkg::PH_IDLE;
		slot_left = '0;
		phase_left = '0;
		slots_to_go = '0;
		epoch_no = snd_pkg::EPOCH_W'(1);
		found_count = '0;
		in_tx_slot = 1'b0;
		foreach (seen_map[i]) seen_map[i] = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Register defaults: ignored kinds, idle ticks, packet checks, start.
		idle_pct = 15;
		pending_items.push_back(make_item(KIND_UNUSED, 7'h7F, 8'hFF));
		pending_items.push_back(make_item(snd_pkg::KIND_TICK, 7'd0, 8'd0));
		pending_items.push_back(make_item(snd_pkg::KIND_RX, 7'd1, 8'd255));
		pending_items.push_back(make_item(snd_pkg::KIND_RX, 7'd1, 8'd255));
		pending_items.push_back(make_item(snd_pkg::KIND_RX, 7'd1, 8'd0));
		pending_items.push_back(make_item(snd_pkg::KIND_RX, 7'd0, 8'd5));
		pending_items.push_back(make_item(snd_pkg::KIND_RX, 7'd127, 8'd6));
		pending_items.push_back(make_item(snd_pkg::KIND_START, 7'd0, 8'd0));
		pending_items.push_back(make_item(snd_pkg::KIND_RX, 7'd1, 8'd7));
		pending_items.push_back(make_item(snd_pkg::KIND_TICK, 7'd0, 8'd0));
		settle();

		// Short burst epoch: beacons, listen window longer than the slot,
		// saturating slot count and an epoch end chained with a new beacon.
		configure(1'b1, 24'd2, 24'd1, 24'd5, 8'd1, 8'd0);
		pending_items.push_back(make_item(snd_pkg::KIND_START, 7'd0, 8'd0));
		repeat (4) pending_items.push_back(make_item(snd_pkg::KIND_TICK, 7'd0, 8'd0));
		pending_items.push_back(make_item(snd_pkg::KIND_RX, 7'd1, 8'd9));
		repeat (6) pending_items.push_back(make_item(snd_pkg::KIND_TICK, 7'd0, 8'd0));
		pending_items.push_back(make_item(snd_pkg::KIND_START, 7'd0, 8'd0));
		pending_items.push_back(make_item(snd_pkg::KIND_TICK, 7'd0, 8'd0));
		settle();

		for (int p = 0; p < 8; p++) begin
			idle_pct = (p == 7) ? 0 : $urandom_range(0, 2) * 15;
			case (p)
				0: configure(1'b0, 24'd1, 24'd1, 24'd1, 8'd1, 8'd255);
				1: configure(1'b1, TICK_MAX, TICK_MAX, TICK_MAX, 8'd255, 8'd0);
				default: configure(1'($urandom_range(0, 1)), 24'($urandom_range(1, 12)),
					24'($urandom_range(1, 6)), 24'($urandom_range(1, 12)),
					8'($urandom_range(1, 4)), 8'($urandom_range(0, 255)));
			endcase
			if ($urandom_range(0, 3) != 0)
				pending_items.push_back(make_item(snd_pkg::KIND_START, 7'd0, 8'd0));
			repeat (200) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					pending_items.push_back(make_item(snd_pkg::KIND_TICK, 7'd0, 8'd0));
				end else if (r < 82) begin
					pick_id = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(1, 24));
					pending_items.push_back(make_item(snd_pkg::KIND_RX, 7'd1, pick_id));
				end else if (r < 94) begin
					pending_items.push_back(make_item(snd_pkg::KIND_RX,
						7'($urandom_range(0, 127)), 8'($urandom_range(0, 255))));
				end else if (r < 98) begin
					pending_items.push_back(make_item(snd_pkg::KIND_START,
						7'($urandom_range(0, 127)), 8'($urandom_range(0, 255))));
				end else begin
					pending_items.push_back(make_item(KIND_UNUSED,
						7'($urandom_range(0, 127)), 8'($urandom_range(0, 255))));
				end
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("PASS slotted_neighbour_discovery");
		end else begin
			$display("FAIL slotted_neighbour_discovery");
		end
		$finish;
	end

endmodule

@@ slotted_neighbour_discovery.f @@
sv/snd_pkg.sv
sv/snd_core.sv
sv/slotted_neighbour_discovery.sv
sim/slotted_neighbour_discovery_tb.sv
